// ----- hw/rtl/histogram_valley_threshold_macros.svh -----
// assertion macros for the histogram valley threshold block
// used by the top level only; compiles to nothing when SYNTHESIS is defined
`ifndef HISTOGRAM_VALLEY_THRESHOLD_MACROS_SVH
`define HISTOGRAM_VALLEY_THRESHOLD_MACROS_SVH
`ifndef SYNTHESIS
// consequent checked in the same cycle as the antecedent
`define HVT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram_valley_threshold: same-cycle check failed");
// consequent checked in the cycle after the antecedent
`define HVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram_valley_threshold: next-cycle check failed");
`else
`define HVT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/hvt_pkg.sv -----
// types, constants and arithmetic helpers for the histogram valley threshold block
// no dependencies; imported by the channels, engine, scaler and top level
`default_nettype none

package hvt_pkg;

  // histogram geometry
  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned BIN_BITS   = 8;
  localparam int unsigned LIMIT_BITS = 20;
  localparam int unsigned RATIO_BITS = 10;
  localparam int unsigned CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_BITS-1:0]   bin_t;
  typedef logic [BIN_BITS-1:0]   pixel_t;
  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [RATIO_BITS-1:0] ratio_t;

  localparam count_t COUNT_MAX = '1;
  localparam bin_t   BIN_MAX   = bin_t'(NUM_BINS - 1);
  localparam bin_t   THR_MAX   = '1;

  // configuration port
  typedef logic [1:0]            cfg_idx_t;
  typedef logic [LIMIT_BITS-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_EXCLUDE = 2'd0;
  localparam cfg_idx_t CFG_LIMIT   = 2'd1;
  localparam cfg_idx_t CFG_RATIO   = 2'd2;

  localparam pixel_t EXCLUDE_RST = 8'd255;
  localparam limit_t LIMIT_RST   = 20'd100;
  localparam ratio_t RATIO_RST   = 10'd714;

  // valley run: a bin and the four below it
  localparam int unsigned RUN_LEN = 5;
  typedef logic [2:0] run_t;
  localparam run_t RUN_DONE = run_t'(RUN_LEN);
  localparam bin_t RUN_SPAN = bin_t'(RUN_LEN - 1);

  // smoothing: floor((7*neighbor + 3*self + 5) / 10), divide by reciprocal
  localparam int unsigned SMOOTH_W_PREV     = 7;
  localparam int unsigned SMOOTH_W_CUR      = 3;
  localparam int unsigned SMOOTH_BIAS       = 5;
  localparam int unsigned SMOOTH_DIV        = 10;
  localparam int unsigned SMOOTH_SUM_BITS   = COUNT_BITS + 4;
  localparam int unsigned SMOOTH_SHIFT      = SMOOTH_SUM_BITS + 4;
  localparam int unsigned SMOOTH_RECIP_BITS = SMOOTH_SHIFT - 3;
  localparam int unsigned SMOOTH_PROD_BITS  = SMOOTH_SUM_BITS + SMOOTH_RECIP_BITS;
  localparam logic [SMOOTH_RECIP_BITS-1:0] SMOOTH_RECIP =
    SMOOTH_RECIP_BITS'(((64'd1 << SMOOTH_SHIFT) + 64'(SMOOTH_DIV) - 64'd1) / 64'(SMOOTH_DIV));

  // threshold scaling: round(bin * ratio / 1000), divide by reciprocal
  localparam int unsigned SCALE_DIV        = 1000;
  localparam int unsigned SCALE_ROUND      = SCALE_DIV / 2;
  localparam int unsigned SCALE_X_BITS     = BIN_BITS + RATIO_BITS;
  localparam int unsigned SCALE_SHIFT      = SCALE_X_BITS + 10;
  localparam int unsigned SCALE_RECIP_BITS = SCALE_SHIFT - 9;
  localparam int unsigned SCALE_PROD_BITS  = SCALE_X_BITS + SCALE_RECIP_BITS;
  localparam int unsigned SCALE_Q_BITS     = SCALE_PROD_BITS - SCALE_SHIFT;
  localparam logic [SCALE_RECIP_BITS-1:0] SCALE_RECIP =
    SCALE_RECIP_BITS'(((64'd1 << SCALE_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

  typedef logic [SCALE_X_BITS-1:0] scale_x_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_COUNT,
    ST_FWD,
    ST_BWD,
    ST_SWEEP,
    ST_REPORT
  } state_t;

  // operation carried with each memory read
  typedef enum logic [2:0] {
    OP_CNT,
    OP_FWD,
    OP_BWD,
    OP_SWP,
    OP_CLR
  } op_t;

  // frame result request from the engine to the scaler
  typedef struct packed {
    logic valid;
    logic found;
    bin_t bin;
  } req_t;

  function automatic count_t smooth_f(count_t nb, count_t cur);
    logic [SMOOTH_SUM_BITS-1:0]  sum;
    logic [SMOOTH_PROD_BITS-1:0] prod;
    sum  = SMOOTH_SUM_BITS'(SMOOTH_W_PREV) * SMOOTH_SUM_BITS'(nb)
         + SMOOTH_SUM_BITS'(SMOOTH_W_CUR) * SMOOTH_SUM_BITS'(cur)
         + SMOOTH_SUM_BITS'(SMOOTH_BIAS);
    prod = SMOOTH_PROD_BITS'(sum) * SMOOTH_PROD_BITS'(SMOOTH_RECIP);
    return count_t'(prod >> SMOOTH_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hvt_channels.sv -----
// valid/ready channel interfaces: pixel input, threshold result, register writes
// depends on hvt_pkg for payload types
`default_nettype none

interface hvt_in_if;
  import hvt_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   last;
  modport source (output valid, pixel, last, input ready);
  modport sink   (input valid, pixel, last, output ready);
endinterface

interface hvt_out_if;
  import hvt_pkg::*;
  logic valid;
  logic ready;
  bin_t threshold;
  logic found;
  modport source (output valid, threshold, found, input ready);
  modport sink   (input valid, threshold, found, output ready);
endinterface

interface hvt_cfg_if;
  import hvt_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  addr;
  cfg_data_t data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hvt_ram.sv -----
// generic single-clock ram, one write port and one registered read port
// read-first on a same-address write; no dependencies
`default_nettype none

module hvt_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage, read data registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hvt_engine.sv -----
// histogram engine: pixel counting, two smoothing passes, peak and valley search
// depends on hvt_pkg, hvt_channels and hvt_ram
`default_nettype none

module hvt_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  hvt_in_if.sink               in_ch,
  input  wire hvt_pkg::pixel_t exclude_level,
  input  wire hvt_pkg::limit_t low_count_limit,
  output hvt_pkg::req_t        req,
  input  wire logic            req_ready
);
  import hvt_pkg::*;

  state_t state_r, state_nxt;
  bin_t   addr_r, addr_nxt;
  logic   tag_v_r, tag_v_nxt;
  op_t    tag_op_r, tag_op_nxt;
  bin_t   tag_addr_r, tag_addr_nxt;
  bin_t   raddr;
  count_t rdata;
  logic   in_acc;

  logic   mem_we;
  bin_t   mem_waddr;
  count_t mem_wdata;
  logic   fwd_v_r;
  bin_t   fwd_addr_r;
  count_t fwd_data_r;

  count_t val;
  count_t smoothed;
  logic   low;
  run_t   run_inc;
  count_t prev_r, prev_nxt;
  bin_t   peak_idx_r, peak_idx_nxt;
  count_t peak_val_r, peak_val_nxt;
  run_t   run_r, run_nxt;
  logic   found_r, found_nxt;
  bin_t   valley_r, valley_nxt;

  hvt_ram #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer: picks the read address and the operation that goes with it
  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    tag_v_nxt    = 1'b0;
    tag_op_nxt   = tag_op_r;
    tag_addr_nxt = addr_r;
    raddr        = addr_r;
    in_ch.ready  = 1'b0;
    in_acc       = 1'b0;
    req.valid    = 1'b0;
    req.found    = found_r;
    req.bin      = valley_r;
    unique case (state_r)
      ST_CLEAR: begin
        tag_v_nxt  = 1'b1;
        tag_op_nxt = OP_CLR;
        addr_nxt   = addr_r - 1'b1;
        if (addr_r == '0) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        in_ch.ready  = 1'b1;
        raddr        = in_ch.pixel;
        tag_addr_nxt = in_ch.pixel;
        tag_op_nxt   = OP_CNT;
        if (in_ch.valid) begin
          in_acc    = 1'b1;
          tag_v_nxt = (in_ch.pixel != exclude_level);
          if (in_ch.last) begin
            state_nxt = ST_FWD;
            addr_nxt  = '0;
          end
        end
      end
      ST_FWD: begin
        tag_v_nxt  = 1'b1;
        tag_op_nxt = OP_FWD;
        addr_nxt   = addr_r + 1'b1;
        if (addr_r == BIN_MAX) begin
          state_nxt = ST_BWD;
          addr_nxt  = BIN_MAX - 1'b1;
        end
      end
      ST_BWD: begin
        tag_v_nxt  = 1'b1;
        tag_op_nxt = OP_BWD;
        addr_nxt   = addr_r - 1'b1;
        if (addr_r == '0) begin
          state_nxt = ST_SWEEP;
          addr_nxt  = BIN_MAX;
        end
      end
      ST_SWEEP: begin
        tag_v_nxt  = 1'b1;
        tag_op_nxt = OP_SWP;
        addr_nxt   = addr_r - 1'b1;
        if (addr_r == '0) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        // wait for the last sweep entry to settle the search
        req.valid = !tag_v_r;
        if (req.valid && req_ready) begin
          state_nxt = ST_COUNT;
        end
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= BIN_MAX;
      tag_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      tag_v_r <= tag_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_op_r   <= tag_op_nxt;
    tag_addr_r <= tag_addr_nxt;
  end

  // read data path: forward the write of the previous edge, then modify
  always_comb begin
    val      = (fwd_v_r && (fwd_addr_r == tag_addr_r)) ? fwd_data_r : rdata;
    smoothed = smooth_f(prev_r, val);
    low      = (CMP_BITS'(val) < CMP_BITS'(low_count_limit));
    run_inc  = run_r + 1'b1;

    mem_we       = 1'b0;
    mem_waddr    = tag_addr_r;
    mem_wdata    = '0;
    prev_nxt     = prev_r;
    peak_idx_nxt = peak_idx_r;
    peak_val_nxt = peak_val_r;
    run_nxt      = run_r;
    found_nxt    = found_r;
    valley_nxt   = valley_r;

    // a new frame end restarts the valley search
    if (in_acc && in_ch.last) begin
      run_nxt   = '0;
      found_nxt = 1'b0;
    end

    if (tag_v_r) begin
      unique case (tag_op_r)
        OP_CNT: begin
          mem_we    = 1'b1;
          mem_wdata = (val == COUNT_MAX) ? val : val + count_t'(1);
        end
        OP_FWD: begin
          if (tag_addr_r == '0) begin
            prev_nxt = val;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = smoothed;
            prev_nxt  = smoothed;
            // top bin is final after the forward pass: seed the peak
            if (tag_addr_r == BIN_MAX) begin
              peak_idx_nxt = BIN_MAX;
              peak_val_nxt = smoothed;
            end
          end
        end
        OP_BWD: begin
          mem_we    = 1'b1;
          mem_wdata = smoothed;
          prev_nxt  = smoothed;
          // walking down, ties move the peak to the lower bin
          if (smoothed >= peak_val_r) begin
            peak_idx_nxt = tag_addr_r;
            peak_val_nxt = smoothed;
          end
        end
        OP_SWP: begin
          mem_we = 1'b1;
          if (!found_r && (tag_addr_r <= peak_idx_r)) begin
            if (low) begin
              run_nxt = run_inc;
              if (run_inc == RUN_DONE) begin
                found_nxt  = 1'b1;
                valley_nxt = tag_addr_r + RUN_SPAN;
              end
            end else begin
              run_nxt = '0;
            end
          end
        end
        OP_CLR: begin
          mem_we = 1'b1;
        end
      endcase
    end
  end

  // forwarding and search control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
      run_r   <= '0;
      found_r <= 1'b0;
    end else begin
      fwd_v_r <= mem_we;
      run_r   <= run_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= mem_waddr;
    fwd_data_r <= mem_wdata;
    prev_r     <= prev_nxt;
    peak_idx_r <= peak_idx_nxt;
    peak_val_r <= peak_val_nxt;
    valley_r   <= valley_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hvt_scale.sv -----
// threshold scaler: round(bin * ratio / 1000) saturated to 8 bits, plus output register
// depends on hvt_pkg and hvt_channels
`default_nettype none

module hvt_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire hvt_pkg::req_t   req,
  output logic                 req_ready,
  input  wire hvt_pkg::ratio_t ratio,
  hvt_out_if.source            out_ch
);
  import hvt_pkg::*;

  logic                       s1_v_r;
  logic                       s1_found_r;
  scale_x_t                   s1_x_r;
  logic [SCALE_PROD_BITS-1:0] prod;
  logic [SCALE_Q_BITS-1:0]    quot;
  bin_t                       thr;
  logic                       advance;
  logic                       out_v_r;
  bin_t                       out_thr_r;
  logic                       out_found_r;

  // handshake between the product stage and the output register
  assign advance   = s1_v_r && (!out_v_r || out_ch.ready);
  assign req_ready = !s1_v_r || advance;

  // divide by 1000 through the reciprocal, then saturate
  always_comb begin
    prod = SCALE_PROD_BITS'(s1_x_r) * SCALE_PROD_BITS'(SCALE_RECIP);
    quot = prod[SCALE_PROD_BITS-1:SCALE_SHIFT];
    thr  = (quot > SCALE_Q_BITS'(THR_MAX)) ? THR_MAX : bin_t'(quot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_v_r <= req.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // product stage and output payload
  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      s1_found_r <= req.found;
      s1_x_r     <= scale_x_t'(req.bin) * scale_x_t'(ratio) + scale_x_t'(SCALE_ROUND);
    end
    if (advance) begin
      out_thr_r   <= s1_found_r ? thr : '0;
      out_found_r <= s1_found_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.threshold = out_thr_r;
  assign out_ch.found     = out_found_r;

endmodule

`default_nettype wire

// ----- hw/rtl/histogram_valley_threshold.sv -----
// Histogram valley threshold, top level.
// Channels: in_ch takes one 8-bit pixel per item, last marks the final pixel
// of a frame; out_ch gives one item per frame (threshold, found); cfg_ch
// writes exclude_level (0), low_count_limit (1) and ratio_thousandths (2),
// other indexes are dropped. cfg_ch is always ready.
// Throughput: one pixel per cycle while a frame is counted; each pixel is a
// read-modify-write of the 256-entry count ram with write forwarding.
// Frame end: after the last pixel in_ch.ready drops while the single ram port
// pair walks the bins: forward smoothing of bins 1 to 255, backward smoothing
// of bins 254 down to 0 with the peak search, the valley search over all 256
// bins that also clears the ram, then settling the search and handing the
// result to the scaler.
// Reset: registers take their defaults and a clearing pass over all 256 entries
// zeroes the ram; in_ch.ready stays low until it ends.
// Stall: the result sits in an output register and the next frame is
// counted meanwhile; a later frame end waits only if that result and the
// one behind it in the scaler are both still untaken.
// Depends on hvt_pkg, hvt_channels, hvt_engine, hvt_scale and the macros header.
`default_nettype none
`include "histogram_valley_threshold_macros.svh"

module histogram_valley_threshold (
  input  wire logic clk,
  input  wire logic rst_n,
  hvt_in_if.sink    in_ch,
  hvt_out_if.source out_ch,
  hvt_cfg_if.sink   cfg_ch
);
  import hvt_pkg::*;

  pixel_t exclude_r;
  limit_t limit_r;
  ratio_t ratio_r;
  req_t   req;
  logic   req_ready;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exclude_r <= EXCLUDE_RST;
      limit_r   <= LIMIT_RST;
      ratio_r   <= RATIO_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.addr)
        CFG_EXCLUDE: exclude_r <= pixel_t'(cfg_ch.data);
        CFG_LIMIT:   limit_r   <= limit_t'(cfg_ch.data);
        CFG_RATIO:   ratio_r   <= ratio_t'(cfg_ch.data);
        default: begin
        end
      endcase
    end
  end

  hvt_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .exclude_level   (exclude_r),
    .low_count_limit (limit_r),
    .req             (req),
    .req_ready       (req_ready)
  );

  hvt_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .ratio     (ratio_r),
    .out_ch    (out_ch)
  );

  // a result without a valley carries a zero threshold
  `HVT_ASSERT_SAME(a_nofound_zero, clk, rst_n, out_ch.valid && !out_ch.found, out_ch.threshold == '0)
  // the frame end shuts the pixel input at once
  `HVT_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.last, !in_ch.ready)
  // handing the result to the scaler reopens the pixel input
  `HVT_ASSERT_NEXT(a_report_resumes, clk, rst_n, req.valid && req_ready, in_ch.ready)

endmodule

`default_nettype wire
